FILE: rtl/uhid_pkg.sv
// Shared types and codes for the HID control endpoint request decoder.
package uhid_pkg;

  // Event codes on req_type
  localparam logic [1:0] EV_BUS_RESET = 2'd0;
  localparam logic [1:0] EV_SETUP     = 2'd1;
  localparam logic [1:0] EV_DATA_OUT  = 2'd2;
  localparam logic [1:0] EV_STATUS    = 2'd3;

  // Result actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_STALL     = 3'd1;
  localparam logic [2:0] ACT_STATUS_IN = 3'd2;
  localparam logic [2:0] ACT_DATA_IN   = 3'd3;
  localparam logic [2:0] ACT_DATA_OUT  = 3'd4;

  // Data-in sources
  localparam logic [3:0] SRC_DEVICE   = 4'd0;
  localparam logic [3:0] SRC_CONFIG   = 4'd1;
  localparam logic [3:0] SRC_STRING   = 4'd2;
  localparam logic [3:0] SRC_HID      = 4'd3;
  localparam logic [3:0] SRC_REPORT   = 4'd4;
  localparam logic [3:0] SRC_CFG_VAL  = 4'd5;
  localparam logic [3:0] SRC_IDLE     = 4'd6;
  localparam logic [3:0] SRC_PROTOCOL = 4'd7;
  localparam logic [3:0] SRC_LEDS     = 4'd8;
  localparam logic [3:0] SRC_KEYBOARD = 4'd9;

  // Data-out targets
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_OUTPUT  = 2'd1;
  localparam logic [1:0] TGT_FEATURE = 2'd2;

  // Configuration commands
  localparam logic [1:0] CCMD_NONE     = 2'd0;
  localparam logic [1:0] CCMD_DECONFIG = 2'd1;
  localparam logic [1:0] CCMD_CONFIG   = 2'd2;

  // Standard requests
  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESC    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

  // HID class requests
  localparam logic [7:0] HID_GET_REPORT   = 8'd1;
  localparam logic [7:0] HID_GET_IDLE     = 8'd2;
  localparam logic [7:0] HID_GET_PROTOCOL = 8'd3;
  localparam logic [7:0] HID_SET_REPORT   = 8'd9;
  localparam logic [7:0] HID_SET_IDLE     = 8'd10;
  localparam logic [7:0] HID_SET_PROTOCOL = 8'd11;

  // Descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_HID    = 8'h21;
  localparam logic [7:0] DT_REPORT = 8'h22;

  // Request kinds in bmRequestType[6:5]
  localparam logic [1:0] KIND_STANDARD = 2'd0;
  localparam logic [1:0] KIND_CLASS    = 2'd1;

  // Report types in wValue high byte
  localparam logic [7:0] RPT_INPUT   = 8'd1;
  localparam logic [7:0] RPT_OUTPUT  = 8'd2;
  localparam logic [7:0] RPT_FEATURE = 8'd3;

  localparam logic [6:0] MAX_ADDRESS = 7'd127;

  // Register indexes
  localparam logic [2:0] REG_DEVICE_DESC_LEN = 3'd0;
  localparam logic [2:0] REG_CONFIG_DESC_LEN = 3'd1;
  localparam logic [2:0] REG_HID_DESC_LEN    = 3'd2;
  localparam logic [2:0] REG_REPORT_DESC_LEN = 3'd3;
  localparam logic [2:0] REG_STRING_COUNT    = 3'd4;
  localparam logic [2:0] REG_STRING_LENGTHS  = 3'd5;
  localparam logic [2:0] REG_KBD_REPORT_LEN  = 3'd6;
  localparam logic [2:0] REG_MAX_PACKET_LOG2 = 3'd7;

  // Side effect a setup packet leaves for the back end
  typedef enum logic [2:0] {
    EFF_NONE,
    EFF_ADDRESS,
    EFF_CONFIG,
    EFF_IDLE,
    EFF_PROTOCOL,
    EFF_OUT_REPORT,
    EFF_OUT_FEATURE
  } eff_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  bm_request_type;
    logic [7:0]  b_request;
    logic [15:0] w_value;
    logic [15:0] w_index;
    logic [15:0] w_length;
    logic [7:0]  out_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  data_source;
    logic [2:0]  string_index;
    logic [7:0]  data_byte;
    logic [15:0] xfer_length;
    logic        needs_zlp;
    logic        address_apply;
    logic [6:0]  address_value;
    logic [1:0]  config_cmd;
    logic        led_update;
    logic [7:0]  led_value;
    logic        configured;
  } out_t;

  typedef struct packed {
    logic [7:0]  device_desc_len;
    logic [15:0] config_desc_len;
    logic [7:0]  hid_desc_len;
    logic [15:0] report_desc_len;
    logic [3:0]  string_count;
    logic [63:0] string_lengths;
    logic [6:0]  kbd_report_len;
    logic [2:0]  max_packet_log2;
  } cfg_t;

  // Classified event queued between front and back
  typedef struct packed {
    logic [1:0]  ev;
    logic [2:0]  action;
    logic [3:0]  src;
    logic [2:0]  string_index;
    logic [15:0] xfer_length;
    logic        needs_zlp;
    eff_t        eff;
    logic [7:0]  arg;
  } cmd_t;

endpackage

FILE: rtl/uhid_cfg_regs.sv
// Configuration register file behind the APB-style port.
module uhid_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output uhid_pkg::cfg_t      cfg
);

  uhid_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[5:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_desc_len <= 8'd18;
      cfg_r.config_desc_len <= 16'd34;
      cfg_r.hid_desc_len    <= 8'd9;
      cfg_r.report_desc_len <= 16'd63;
      cfg_r.string_count    <= 4'd4;
      cfg_r.string_lengths  <= 64'd0;
      cfg_r.kbd_report_len  <= 7'd8;
      cfg_r.max_packet_log2 <= 3'd3;
    end else if (wr_en) begin
      case (reg_idx)
        uhid_pkg::REG_DEVICE_DESC_LEN: cfg_r.device_desc_len <= pwdata[7:0];
        uhid_pkg::REG_CONFIG_DESC_LEN: cfg_r.config_desc_len <= pwdata[15:0];
        uhid_pkg::REG_HID_DESC_LEN:    cfg_r.hid_desc_len    <= pwdata[7:0];
        uhid_pkg::REG_REPORT_DESC_LEN: cfg_r.report_desc_len <= pwdata[15:0];
        uhid_pkg::REG_STRING_COUNT:    cfg_r.string_count    <= pwdata[3:0];
        uhid_pkg::REG_STRING_LENGTHS:  cfg_r.string_lengths  <= pwdata;
        uhid_pkg::REG_KBD_REPORT_LEN:  cfg_r.kbd_report_len  <= pwdata[6:0];
        uhid_pkg::REG_MAX_PACKET_LOG2: cfg_r.max_packet_log2 <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      uhid_pkg::REG_DEVICE_DESC_LEN: prdata = {56'd0, cfg_r.device_desc_len};
      uhid_pkg::REG_CONFIG_DESC_LEN: prdata = {48'd0, cfg_r.config_desc_len};
      uhid_pkg::REG_HID_DESC_LEN:    prdata = {56'd0, cfg_r.hid_desc_len};
      uhid_pkg::REG_REPORT_DESC_LEN: prdata = {48'd0, cfg_r.report_desc_len};
      uhid_pkg::REG_STRING_COUNT:    prdata = {60'd0, cfg_r.string_count};
      uhid_pkg::REG_STRING_LENGTHS:  prdata = cfg_r.string_lengths;
      uhid_pkg::REG_KBD_REPORT_LEN:  prdata = {57'd0, cfg_r.kbd_report_len};
      uhid_pkg::REG_MAX_PACKET_LOG2: prdata = {61'd0, cfg_r.max_packet_log2};
      default:                       prdata = 64'd0;
    endcase
  end

endmodule

FILE: rtl/uhid_front.sv
// Front end: classify one endpoint-0 event into a queued command.
module uhid_front #(
  parameter int MAX_STRINGS = 8
) (
  input  uhid_pkg::in_t   item,
  input  uhid_pkg::cfg_t  cfg,
  output uhid_pkg::cmd_t  cmd
);

  localparam logic [3:0] MAX_STR = 4'(MAX_STRINGS);

  logic        d2h;
  logic [1:0]  kind;
  logic [7:0]  hi;
  logic [7:0]  lo;
  logic        idx_zero;
  logic [3:0]  str_cnt;
  logic [15:0] src_len;
  logic        use_len;      // data-in sized by min(length, wLength)
  logic [15:0] xfer;
  logic [2:0]  lg;
  logic [5:0]  pkt_mask;
  logic [7:0]  str_len;

  assign d2h      = item.bm_request_type[7];
  assign kind     = item.bm_request_type[6:5];
  assign hi       = item.w_value[15:8];
  assign lo       = item.w_value[7:0];
  assign idx_zero = (item.w_index == 16'd0);
  assign str_cnt  = (cfg.string_count < MAX_STR) ? cfg.string_count : MAX_STR;
  assign str_len  = cfg.string_lengths[{lo[2:0], 3'b000} +: 8];

  // Clamp packet size to 8..64 bytes
  always_comb begin
    if (cfg.max_packet_log2 < 3'd3)      lg = 3'd3;
    else if (cfg.max_packet_log2 > 3'd6) lg = 3'd6;
    else                                 lg = cfg.max_packet_log2;
  end
  assign pkt_mask = 6'((7'd1 << lg) - 7'd1);

  assign xfer = (src_len < item.w_length) ? src_len : item.w_length;

  always_comb begin
    cmd              = '0;
    cmd.ev           = item.req_type;
    cmd.eff          = uhid_pkg::EFF_NONE;
    src_len          = 16'd0;
    use_len          = 1'b0;
    case (item.req_type)
      uhid_pkg::EV_DATA_OUT: begin
        cmd.arg = item.out_data;
      end
      uhid_pkg::EV_SETUP: begin
        cmd.action = uhid_pkg::ACT_STALL;
        if (kind == uhid_pkg::KIND_STANDARD) begin
          case (item.b_request)
            uhid_pkg::REQ_GET_DESC: begin
              case (hi)
                uhid_pkg::DT_DEVICE: begin
                  cmd.src = uhid_pkg::SRC_DEVICE;
                  src_len = {8'd0, cfg.device_desc_len};
                  use_len = 1'b1;
                end
                uhid_pkg::DT_CONFIG: begin
                  cmd.src = uhid_pkg::SRC_CONFIG;
                  src_len = cfg.config_desc_len;
                  use_len = 1'b1;
                end
                uhid_pkg::DT_STRING: begin
                  if (lo < {4'd0, str_cnt}) begin
                    cmd.src          = uhid_pkg::SRC_STRING;
                    cmd.string_index = lo[2:0];
                    src_len          = {8'd0, str_len};
                    use_len          = 1'b1;
                  end
                end
                uhid_pkg::DT_HID: begin
                  cmd.src = uhid_pkg::SRC_HID;
                  src_len = {8'd0, cfg.hid_desc_len};
                  use_len = 1'b1;
                end
                uhid_pkg::DT_REPORT: begin
                  cmd.src = uhid_pkg::SRC_REPORT;
                  src_len = cfg.report_desc_len;
                  use_len = 1'b1;
                end
                default: ;
              endcase
            end
            uhid_pkg::REQ_SET_ADDRESS: begin
              if (!d2h && item.w_value <= {9'd0, uhid_pkg::MAX_ADDRESS} && idx_zero &&
                  item.w_length == 16'd0) begin
                cmd.action = uhid_pkg::ACT_STATUS_IN;
                cmd.eff    = uhid_pkg::EFF_ADDRESS;
                cmd.arg    = lo;
              end
            end
            uhid_pkg::REQ_GET_CONFIG: begin
              if (d2h && item.w_value == 16'd0 && idx_zero && item.w_length == 16'd1) begin
                cmd.action      = uhid_pkg::ACT_DATA_IN;
                cmd.src         = uhid_pkg::SRC_CFG_VAL;
                cmd.xfer_length = 16'd1;
              end
            end
            uhid_pkg::REQ_SET_CONFIG: begin
              if (!d2h && item.w_value <= 16'd1 && idx_zero && item.w_length == 16'd0) begin
                cmd.action = uhid_pkg::ACT_STATUS_IN;
                cmd.eff    = uhid_pkg::EFF_CONFIG;
                cmd.arg    = lo;
              end
            end
            default: ;
          endcase
        end else if (kind == uhid_pkg::KIND_CLASS && idx_zero) begin
          case (item.b_request)
            uhid_pkg::HID_SET_IDLE: begin
              if (!d2h && lo == 8'd0 && item.w_length == 16'd0) begin
                cmd.action = uhid_pkg::ACT_STATUS_IN;
                cmd.eff    = uhid_pkg::EFF_IDLE;
                cmd.arg    = hi;
              end
            end
            uhid_pkg::HID_GET_IDLE: begin
              if (d2h && item.w_value == 16'd0 && item.w_length == 16'd1) begin
                cmd.action      = uhid_pkg::ACT_DATA_IN;
                cmd.src         = uhid_pkg::SRC_IDLE;
                cmd.xfer_length = 16'd1;
              end
            end
            uhid_pkg::HID_SET_PROTOCOL: begin
              if (!d2h && item.w_value <= 16'd1 && item.w_length == 16'd0) begin
                cmd.action = uhid_pkg::ACT_STATUS_IN;
                cmd.eff    = uhid_pkg::EFF_PROTOCOL;
                cmd.arg    = lo;
              end
            end
            uhid_pkg::HID_GET_PROTOCOL: begin
              if (d2h && item.w_value == 16'd0 && item.w_length == 16'd1) begin
                cmd.action      = uhid_pkg::ACT_DATA_IN;
                cmd.src         = uhid_pkg::SRC_PROTOCOL;
                cmd.xfer_length = 16'd1;
              end
            end
            uhid_pkg::HID_SET_REPORT: begin
              if (!d2h && lo == 8'd0) begin
                if (hi == uhid_pkg::RPT_OUTPUT) begin
                  cmd.action      = uhid_pkg::ACT_DATA_OUT;
                  cmd.eff         = uhid_pkg::EFF_OUT_REPORT;
                  cmd.xfer_length = 16'd1;
                end else if (hi == uhid_pkg::RPT_FEATURE) begin
                  cmd.action      = uhid_pkg::ACT_DATA_OUT;
                  cmd.eff         = uhid_pkg::EFF_OUT_FEATURE;
                  cmd.xfer_length = item.w_length;
                end
              end
            end
            uhid_pkg::HID_GET_REPORT: begin
              if (d2h && lo == 8'd0) begin
                if (hi == uhid_pkg::RPT_OUTPUT) begin
                  cmd.src = uhid_pkg::SRC_LEDS;
                  src_len = 16'd1;
                  use_len = 1'b1;
                end else if (hi == uhid_pkg::RPT_INPUT) begin
                  if (cfg.kbd_report_len == 7'd0) begin
                    // no report ready: answer nothing
                    cmd.action = uhid_pkg::ACT_NONE;
                  end else begin
                    cmd.src = uhid_pkg::SRC_KEYBOARD;
                    src_len = {9'd0, cfg.kbd_report_len};
                    use_len = 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        if (use_len) begin
          cmd.action      = uhid_pkg::ACT_DATA_IN;
          cmd.xfer_length = xfer;
          cmd.needs_zlp   = (xfer < item.w_length) && ((xfer[5:0] & pkt_mask) == 6'd0);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/uhid_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
module uhid_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  uhid_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output uhid_pkg::cmd_t  pop_data,
  output logic            empty
);

  uhid_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 2'd1;
    else if (!do_push && do_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count beyond depth");

endmodule

FILE: rtl/uhid_back.sv
// Back end: apply queued commands to device state and register the result.
module uhid_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_avail,
  input  uhid_pkg::cmd_t  cmd,
  output logic            cmd_take,
  output logic            out_valid,
  input  logic            out_stall,
  output uhid_pkg::out_t  out_data
);

  logic [6:0] dev_addr_r, dev_addr_nxt;
  logic [6:0] pend_addr_r, pend_addr_nxt;
  logic       addr_pend_r, addr_pend_nxt;
  logic       conf_r, conf_nxt;
  logic       pend_conf_r, pend_conf_nxt;
  logic       conf_pend_r, conf_pend_nxt;
  logic [1:0] target_r, target_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic       proto_r, proto_nxt;
  logic [7:0] led_r, led_nxt;

  logic           out_valid_r;
  uhid_pkg::out_t out_r;
  uhid_pkg::out_t res;

  // Advance when the output register is empty or being drained
  assign cmd_take  = cmd_avail & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    dev_addr_nxt  = dev_addr_r;
    pend_addr_nxt = pend_addr_r;
    addr_pend_nxt = addr_pend_r;
    conf_nxt      = conf_r;
    pend_conf_nxt = pend_conf_r;
    conf_pend_nxt = conf_pend_r;
    target_nxt    = target_r;
    idle_nxt      = idle_r;
    proto_nxt     = proto_r;
    led_nxt       = led_r;
    res           = '0;
    case (cmd.ev)
      uhid_pkg::EV_BUS_RESET: begin
        dev_addr_nxt  = 7'd0;
        pend_addr_nxt = 7'd0;
        addr_pend_nxt = 1'b0;
        conf_nxt      = 1'b0;
        pend_conf_nxt = 1'b0;
        conf_pend_nxt = 1'b0;
        target_nxt    = uhid_pkg::TGT_NONE;
        idle_nxt      = 8'd0;
        proto_nxt     = 1'b0;
        led_nxt       = 8'd0;
      end
      uhid_pkg::EV_SETUP: begin
        // drop anything left pending by the previous transfer
        addr_pend_nxt    = 1'b0;
        conf_pend_nxt    = 1'b0;
        target_nxt       = uhid_pkg::TGT_NONE;
        res.action       = cmd.action;
        res.data_source  = cmd.src;
        res.string_index = cmd.string_index;
        res.xfer_length  = cmd.xfer_length;
        res.needs_zlp    = cmd.needs_zlp;
        if (cmd.action == uhid_pkg::ACT_DATA_IN) begin
          case (cmd.src)
            uhid_pkg::SRC_CFG_VAL:  res.data_byte = {7'd0, conf_r};
            uhid_pkg::SRC_IDLE:     res.data_byte = idle_r;
            uhid_pkg::SRC_PROTOCOL: res.data_byte = {7'd0, proto_r};
            uhid_pkg::SRC_LEDS:     res.data_byte = led_r;
            default:                res.data_byte = 8'd0;
          endcase
        end
        case (cmd.eff)
          uhid_pkg::EFF_ADDRESS: begin
            pend_addr_nxt = cmd.arg[6:0];
            addr_pend_nxt = 1'b1;
          end
          uhid_pkg::EFF_CONFIG: begin
            pend_conf_nxt = cmd.arg[0];
            conf_pend_nxt = 1'b1;
          end
          uhid_pkg::EFF_IDLE:        idle_nxt   = cmd.arg;
          uhid_pkg::EFF_PROTOCOL:    proto_nxt  = cmd.arg[0];
          uhid_pkg::EFF_OUT_REPORT:  target_nxt = uhid_pkg::TGT_OUTPUT;
          uhid_pkg::EFF_OUT_FEATURE: target_nxt = uhid_pkg::TGT_FEATURE;
          default: ;
        endcase
      end
      uhid_pkg::EV_DATA_OUT: begin
        if (target_r == uhid_pkg::TGT_OUTPUT) begin
          led_nxt        = cmd.arg;
          target_nxt     = uhid_pkg::TGT_NONE;
          res.action     = uhid_pkg::ACT_STATUS_IN;
          res.led_update = 1'b1;
        end else if (target_r != uhid_pkg::TGT_FEATURE) begin
          res.action = uhid_pkg::ACT_STALL;
        end
      end
      default: begin
        // status stage done: commit pending address and configuration
        if (addr_pend_r) begin
          addr_pend_nxt     = 1'b0;
          dev_addr_nxt      = pend_addr_r;
          res.address_apply = 1'b1;
        end
        if (conf_pend_r) begin
          conf_pend_nxt  = 1'b0;
          conf_nxt       = pend_conf_r;
          res.config_cmd = pend_conf_r ? uhid_pkg::CCMD_CONFIG : uhid_pkg::CCMD_DECONFIG;
        end
      end
    endcase
    res.address_value = dev_addr_nxt;
    res.led_value     = led_nxt;
    res.configured    = conf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= 7'd0;
      pend_addr_r <= 7'd0;
      addr_pend_r <= 1'b0;
      conf_r      <= 1'b0;
      pend_conf_r <= 1'b0;
      conf_pend_r <= 1'b0;
      target_r    <= uhid_pkg::TGT_NONE;
      idle_r      <= 8'd0;
      proto_r     <= 1'b0;
      led_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_take) begin
        dev_addr_r  <= dev_addr_nxt;
        pend_addr_r <= pend_addr_nxt;
        addr_pend_r <= addr_pend_nxt;
        conf_r      <= conf_nxt;
        pend_conf_r <= pend_conf_nxt;
        conf_pend_r <= conf_pend_nxt;
        target_r    <= target_nxt;
        idle_r      <= idle_nxt;
        proto_r     <= proto_nxt;
        led_r       <= led_nxt;
      end
      if (cmd_take)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_r <= res;
    end
  end

  a_led_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.led_update |-> out_r.action == uhid_pkg::ACT_STATUS_IN)
    else $error("led update without status stage");

  a_apply_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.address_apply || out_r.config_cmd != uhid_pkg::CCMD_NONE)
    |-> out_r.action == uhid_pkg::ACT_NONE)
    else $error("commit carried an endpoint action");

  a_target_code: assert property (@(posedge clk) disable iff (!rst_n)
    target_r != 2'd3) else $error("data-out target out of range");

  a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take && cmd.ev == uhid_pkg::EV_BUS_RESET |=>
    dev_addr_r == 7'd0 && led_r == 8'd0 && !conf_r && !addr_pend_r)
    else $error("bus reset left device state behind");

endmodule

FILE: rtl/usb_hid_control_request_handler.sv
// Top level of the USB HID control endpoint request decoder.
// An accepted event is decoded into the two-entry command queue; the back end then
// applies it and registers the result in the output register.
// Throughput: one event per cycle; the back end drains one command per cycle while
// the output register is free, and in_stall rises only when the queue holds two.
// Reset (rst_n low, synchronous): clears the queue, the output valid flag and all
// device state, and loads the configuration registers with their defaults.
module usb_hid_control_request_handler #(
  parameter int MAX_STRINGS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  // event channel
  input  logic            in_valid,
  output logic            in_stall,
  input  uhid_pkg::in_t   in_data,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output uhid_pkg::out_t  out_data,
  // configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [5:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready
);

  uhid_pkg::cfg_t cfg;
  uhid_pkg::cmd_t front_cmd;
  uhid_pkg::cmd_t back_cmd;
  logic           q_full;
  logic           q_empty;
  logic           back_take;

  uhid_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: classify the beat as it is accepted; no device state is read here
  uhid_front #(
    .MAX_STRINGS (MAX_STRINGS)
  ) u_front (
    .item (in_data),
    .cfg  (cfg),
    .cmd  (front_cmd)
  );

  // Hold the input only when both queue slots are taken
  assign in_stall = q_full;

  uhid_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (back_take),
    .pop_data  (back_cmd),
    .empty     (q_empty)
  );

  // Back: apply state changes and fill the output register
  uhid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (~q_empty),
    .cmd       (back_cmd),
    .cmd_take  (back_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
